FILE: sv/assert_macros.svh
// Assertion macros used by the RTL file that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// Condition that holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("invariant check failed");

`endif

FILE: sv/wamt_pkg.sv
// Shared types, codes and saturating arithmetic for the window-add range-max tree.
package wamt_pkg;

  localparam int POSITIONS_DEF = 1024;
  localparam int VAL_W         = 48;
  localparam int CFG_W         = 11;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic REG_USED_SIZE  = 1'b0;
  localparam logic REG_WINDOW_LEN = 1'b1;

  typedef logic [VAL_W-1:0] val_t;

  // One tree node: subtree maximum and the add still owed to the children.
  typedef struct packed {
    val_t mx;
    val_t pd;
  } node_t;

  // Port of the node memory that takes writes.
  typedef struct packed {
    logic  we;
    node_t data;
  } node_wr_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic [VAL_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[VAL_W] ? '1 : s[VAL_W-1:0];
  endfunction

endpackage

FILE: sv/wamt_ram.sv
// Node memory: one write port and one registered read port.
module wamt_ram #(
  parameter int AW = 11
) (
  input  logic               clk_i,
  input  wamt_pkg::node_wr_t wr_i,
  input  logic [AW-1:0]      waddr_i,
  input  logic [AW-1:0]      raddr_i,
  output wamt_pkg::node_t    rdata_o
);
  import wamt_pkg::*;

  node_t mem [2**AW];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[waddr_i] <= wr_i.data;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: sv/window_add_range_max_tree_unit.sv
// Window-add / range-maximum store built as a lazy segment tree walked by a small sequencer.
// An add that touches no position is finished when it is accepted, and an empty query goes
// straight to loading its result; otherwise the walk reads and then evaluates each node it
// visits, pushes a pending add to both children where one is found, and returns step by step
// to the root, and a query then loads its result. The walk reads one node at a time through
// the single read port of the node memory. A query result then waits in the output register.
// After reset a clearing pass writes every node to zero before the first item is taken;
// configuration writes are taken throughout.
`include "assert_macros.svh"

module window_add_range_max_tree_unit #(
  parameter int POSITIONS = wamt_pkg::POSITIONS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [wamt_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                     s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [9:0] first_pos, [41:10] second_arg, [47:42] zero
  input  logic [47:0]              s_axis_tdata_i,
  // [0] op
  input  logic                     s_axis_tuser_i,
  output logic                     m_axis_tvalid_o,
  input  logic                     m_axis_tready_i,
  // [47:0] max_value
  output logic [47:0]              m_axis_tdata_o
);
  import wamt_pkg::*;

  localparam int PW = $clog2(POSITIONS);
  localparam int NW = PW + 1;
  localparam int DW = $clog2(PW + 1);

  typedef enum logic [2:0] {IDLE, DOWN, EVAL, PUSH_L, PUSH_R, UP, FINISH} st_e;

  st_e              st_q;
  logic             clr_q;
  logic [NW-1:0]    clr_cnt_q;
  logic [CFG_W-1:0] used_q, wlen_q;
  logic             op_q;
  logic [PW-1:0]    a_q, b_q;
  logic [31:0]      v_q;
  logic [NW-1:0]    node_q;
  logic [DW-1:0]    dep_q;
  val_t             ret_q, pend_q;
  val_t             lres_q [PW+1];
  logic             out_v_q;
  val_t             out_d_q;

  node_wr_t         wr;
  logic [NW-1:0]    waddr, raddr;
  node_t            rd;

  wamt_ram #(.AW(NW)) u_ram (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .waddr_i (waddr),
    .raddr_i (raddr),
    .rdata_o (rd)
  );

  // Range of the current node
  logic [DW-1:0] shamt;
  logic [NW-1:0] lo_sh, left, parent;
  logic [PW-1:0] pos_lo, pos_hi;
  logic          dis, cov;
  logic [DW-1:0] dp;
  val_t          comb_max, v_ext;

  assign shamt    = DW'(PW) - dep_q;
  assign lo_sh    = node_q << shamt;
  assign pos_lo   = lo_sh[PW-1:0];
  assign pos_hi   = pos_lo | ((PW'(1) << shamt) - PW'(1));
  assign dis      = (b_q < pos_lo) || (pos_hi < a_q);
  assign cov      = (a_q <= pos_lo) && (pos_hi <= b_q);
  assign left     = {node_q[NW-2:0], 1'b0};
  assign parent   = node_q >> 1;
  assign dp       = dep_q - DW'(1);
  assign comb_max = (lres_q[dp] > ret_q) ? lres_q[dp] : ret_q;
  assign v_ext    = VAL_W'(v_q);

  // Window and range bounds of an incoming item
  logic [32:0] f33, s33, u33, um1, wl33, f1, lo33, hi33;
  logic        go;

  always_comb begin
    f33  = 33'(s_axis_tdata_i[9:0]);
    s33  = 33'(s_axis_tdata_i[41:10]);
    wl33 = 33'(wlen_q);
    u33  = (33'(used_q) > 33'(POSITIONS)) ? 33'(POSITIONS) : 33'(used_q);
    um1  = u33 - 33'd1;
    f1   = f33 + 33'd1;
    if (s_axis_tuser_i == OP_ADD) begin
      lo33 = (f1 >= wl33) ? f1 - wl33 : '0;
      hi33 = (f33 < um1) ? f33 : um1;
      go   = (u33 != '0) && (wl33 != '0) && (s33 != '0) && (lo33 <= hi33);
    end else begin
      lo33 = f33;
      hi33 = (s33 < um1) ? s33 : um1;
      go   = (u33 != '0) && (lo33 <= hi33);
    end
  end

  assign s_axis_tready_o = (st_q == IDLE) && !clr_q;
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_d_q;

  // Node memory port control
  always_comb begin
    wr.we   = 1'b0;
    wr.data = '0;
    waddr   = node_q;
    raddr   = node_q;
    if (clr_q) begin
      wr.we = 1'b1;
      waddr = clr_cnt_q;
    end else begin
      case (st_q)
        EVAL: begin
          if (dis) begin
            wr.we = 1'b0;
          end else if (cov) begin
            wr.we   = (op_q == OP_ADD);
            wr.data = '{mx: sat_add(rd.mx, v_ext), pd: sat_add(rd.pd, v_ext)};
          end else begin
            wr.we   = (rd.pd != '0);
            wr.data = '{mx: rd.mx, pd: '0};
            raddr   = left;
          end
        end
        PUSH_L: begin
          wr.we   = 1'b1;
          waddr   = left;
          wr.data = '{mx: sat_add(rd.mx, pend_q), pd: sat_add(rd.pd, pend_q)};
          raddr   = left | NW'(1);
        end
        PUSH_R: begin
          wr.we   = 1'b1;
          waddr   = left | NW'(1);
          wr.data = '{mx: sat_add(rd.mx, pend_q), pd: sat_add(rd.pd, pend_q)};
        end
        UP: begin
          wr.we   = (node_q != NW'(1)) && node_q[0] && (op_q == OP_ADD);
          waddr   = parent;
          wr.data = '{mx: comb_max, pd: '0};
        end
        default: begin
          wr.we = 1'b0;
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= CFG_W'(1024);
      wlen_q <= CFG_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_USED_SIZE:  used_q <= cfg_wdata_i;
        REG_WINDOW_LEN: wlen_q <= cfg_wdata_i;
        default:        used_q <= used_q;
      endcase
    end
  end

  // Walk sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= IDLE;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      out_v_q   <= 1'b0;
    end else begin
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + NW'(1);
        if (clr_cnt_q == '1) begin
          clr_q <= 1'b0;
        end
      end
      if (out_v_q && m_axis_tready_i) begin
        out_v_q <= 1'b0;
      end
      case (st_q)
        IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            op_q   <= s_axis_tuser_i;
            a_q    <= lo33[PW-1:0];
            b_q    <= hi33[PW-1:0];
            v_q    <= s_axis_tdata_i[41:10];
            node_q <= NW'(1);
            dep_q  <= '0;
            ret_q  <= '0;
            if (go) begin
              st_q <= DOWN;
            end else if (s_axis_tuser_i == OP_QUERY) begin
              st_q <= FINISH;
            end
          end
        end
        DOWN: st_q <= EVAL;
        EVAL: begin
          if (dis) begin
            ret_q <= (op_q == OP_ADD) ? rd.mx : '0;
            st_q  <= UP;
          end else if (cov) begin
            ret_q <= (op_q == OP_ADD) ? sat_add(rd.mx, v_ext) : rd.mx;
            st_q  <= UP;
          end else if (rd.pd != '0) begin
            pend_q <= rd.pd;
            st_q   <= PUSH_L;
          end else begin
            node_q <= left;
            dep_q  <= dep_q + DW'(1);
            st_q   <= DOWN;
          end
        end
        PUSH_L: st_q <= PUSH_R;
        PUSH_R: begin
          node_q <= left;
          dep_q  <= dep_q + DW'(1);
          st_q   <= DOWN;
        end
        UP: begin
          if (node_q == NW'(1)) begin
            st_q <= (op_q == OP_QUERY) ? FINISH : IDLE;
          end else if (!node_q[0]) begin
            // hold the left result and descend into the sibling
            lres_q[dp] <= ret_q;
            node_q     <= node_q | NW'(1);
            st_q       <= DOWN;
          end else begin
            ret_q  <= comb_max;
            node_q <= parent;
            dep_q  <= dp;
          end
        end
        FINISH: begin
          if (!out_v_q || m_axis_tready_i) begin
            out_v_q <= 1'b1;
            out_d_q <= ret_q;
            st_q    <= IDLE;
          end
        end
        default: st_q <= IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_depth_matches_node, st_q == EVAL, (node_q >> dep_q) == NW'(1))
  `ASSERT_IMPL(a_result_from_finish, $rose(m_axis_tvalid_o), $past(st_q == FINISH))
  `ASSERT_IMPL(a_clear_while_idle, clr_q, st_q == IDLE)

endmodule
